// ===== hdl/p2c_pkg.sv =====
// Shared types and constants of the planar-to-chunky run extractor.
package p2c_pkg;

  // Stream and pixel geometry
  localparam int BYTE_W       = 8;
  localparam int PIX_PER_BYTE = 8;
  localparam int PIX_CNT_W    = 4;   // holds 0..8
  localparam int POS_W        = 3;   // pixel position inside a byte
  localparam int IDX_W        = 13;  // byte index inside a plane row
  localparam int ROW_BYTES_W  = 14;  // padded plane row length in bytes

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int CLIP_W      = 9;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_CLIP_WIDTH   = 3'd2,
    REG_CLIP_HEIGHT  = 3'd3,
    REG_ORIGIN_X     = 3'd4,
    REG_ORIGIN_Y     = 3'd5
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 16'd170;
  localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 16'd28;
  localparam logic [CLIP_W-1:0]     CLIP_WIDTH_RST   = 9'd170;
  localparam logic [CFG_DATA_W-1:0] CLIP_HEIGHT_RST  = 16'd28;
  localparam logic [CFG_DATA_W-1:0] ORIGIN_X_RST     = 16'd0;
  localparam logic [CFG_DATA_W-1:0] ORIGIN_Y_RST     = 16'd0;

  // Result item layout in out_tdata
  localparam int ROW_W           = 16;
  localparam int RUN_Y_W         = 18;
  localparam int RUN_X_W         = 17;
  localparam int COLOR_W         = 3;
  localparam int OUT_DATA_W      = 56;
  localparam int RUN_Y_LSB       = 0;
  localparam int RUN_X_FIRST_LSB = 18;
  localparam int RUN_X_FINAL_LSB = 35;
  localparam int COLOR_LSB       = 52;

  // Control that travels with a decoded top-plane byte
  typedef struct packed {
    logic                 start_closed;  // a row ended since the previous drawn byte
    logic                 hits_end;      // this byte holds the last drawn column
    logic [PIX_CNT_W-1:0] end_cnt;       // drawn pixels in this byte, 1..8
  } run_ctl_t;

endpackage

// ===== hdl/p2c_row_store.sv =====
// Row store: lower-plane bytes of the current row, one byte lane per plane.
module p2c_row_store #(
  parameter int DEPTH = 32,
  parameter int LANES = 2,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int LSEL_W = (LANES > 1) ? $clog2(LANES) : 1
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [ADDR_W-1:0]                     wr_addr,
  input  logic [LSEL_W-1:0]                     wr_lane,
  input  logic [p2c_pkg::BYTE_W-1:0]            wr_byte,
  input  logic                                  rd_en,
  input  logic [ADDR_W-1:0]                     rd_addr,
  output logic [LANES*p2c_pkg::BYTE_W-1:0]      rd_data
);
  import p2c_pkg::*;

  logic [LANES*BYTE_W-1:0] mem [DEPTH];

  // Byte-lane write: a plane only touches its own lane of the entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][int'(wr_lane)*BYTE_W +: BYTE_W] <= wr_byte;
    end
  end

  // Registered read; the data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/p2c_run_walker.sv =====
// Run walker: merges decoded pixels into runs, one closed run per cycle while the output is free.
module p2c_run_walker #(
  parameter int PLANE_COUNT = 3,
  parameter int XW = 9
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  // decoded byte from the staging stage
  input  logic                                            ld_valid,
  output logic                                            ld_ready,
  input  logic [p2c_pkg::PIX_PER_BYTE-1:0][PLANE_COUNT-1:0] ld_pix,
  input  logic [XW-1:0]                                   ld_base,
  input  logic [p2c_pkg::ROW_W-1:0]                       ld_row,
  input  p2c_pkg::run_ctl_t                               ld_ctl,
  // placement
  input  logic [p2c_pkg::CFG_DATA_W-1:0]                  origin_x,
  input  logic [p2c_pkg::CFG_DATA_W-1:0]                  origin_y,
  // result channel
  output logic                                            out_tvalid,
  input  logic                                            out_tready,
  output logic [p2c_pkg::OUT_DATA_W-1:0]                  out_tdata,
  output logic                                            out_tlast
);
  import p2c_pkg::*;

  typedef logic [PIX_PER_BYTE-1:0][PLANE_COUNT-1:0] pix_t;
  typedef logic [PLANE_COUNT-1:0] col_t;

  // First position after 'from' whose color differs from col, else lim
  function automatic logic [PIX_CNT_W-1:0] next_change(input pix_t pix,
                                                      input logic [POS_W-1:0] from,
                                                      input col_t col,
                                                      input logic [PIX_CNT_W-1:0] lim);
    logic [PIX_CNT_W-1:0] j;
    j = lim;
    for (int k = PIX_PER_BYTE - 1; k >= 1; k--) begin
      if ((PIX_CNT_W'(k) > {1'b0, from}) && (PIX_CNT_W'(k) < lim) && (pix[k] != col)) begin
        j = PIX_CNT_W'(k);
      end
    end
    return j;
  endfunction

  // Byte being walked
  logic                 wk_valid_r, wk_valid_nxt;
  pix_t                 pix_r;
  logic [XW-1:0]        base_r;
  logic [ROW_W-1:0]     row_r;
  logic [PIX_CNT_W-1:0] end_r;
  logic                 hits_r;
  logic [POS_W-1:0]     pos_r;

  // Open run
  logic                 run_open_r, run_open_nxt;
  logic [XW-1:0]        run_first_r;
  col_t                 run_col_r;

  // Output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  // Step decode
  col_t                 col_p, col_j;
  logic                 case_a;
  logic [PIX_CNT_W-1:0] j, j2;
  logic                 j_lt, j2_lt;
  logic [XW-1:0]        pos_x, j_x, end_x;
  logic                 emit, elast, done;
  logic [XW-1:0]        efirst, efinal;
  col_t                 ecol;
  logic [XW-1:0]        nfirst;
  col_t                 ncol;
  logic                 nopen;
  logic [POS_W-1:0]     npos;
  logic                 out_free, step, load;
  logic [RUN_Y_W-1:0]   y_val;
  logic [RUN_X_W-1:0]   xf_val, xl_val;

  assign col_p  = pix_r[pos_r];
  assign case_a = run_open_r && (col_p != run_col_r);
  assign j      = next_change(pix_r, pos_r, col_p, end_r);
  assign j_lt   = j < end_r;
  assign col_j  = pix_r[j[POS_W-1:0]];
  assign j2     = next_change(pix_r, j[POS_W-1:0], col_j, end_r);
  assign j2_lt  = j2 < end_r;
  assign pos_x  = base_r + XW'(pos_r);
  assign j_x    = base_r + XW'(j);
  assign end_x  = base_r + XW'(end_r);

  // One walk step: close a run at a color change or at the drawn edge
  always_comb begin
    emit   = 1'b0;
    elast  = 1'b0;
    done   = 1'b0;
    efirst = run_first_r;
    efinal = pos_x;
    ecol   = run_col_r;
    nfirst = run_first_r;
    ncol   = run_col_r;
    nopen  = run_open_r;
    npos   = pos_r;
    if (case_a) begin
      // run from the previous byte ends just before this byte
      emit   = 1'b1;
      efinal = pos_x - XW'(1);
      elast  = !(hits_r || j_lt);
      nfirst = pos_x;
      ncol   = col_p;
      nopen  = 1'b1;
    end else begin
      efirst = run_open_r ? run_first_r : pos_x;
      ecol   = col_p;
      if (j_lt) begin
        emit   = 1'b1;
        efinal = j_x - XW'(1);
        elast  = !(hits_r || j2_lt);
        nfirst = j_x;
        ncol   = col_j;
        nopen  = 1'b1;
        npos   = j[POS_W-1:0];
      end else begin
        // rest of the byte is one color
        emit   = hits_r;
        efinal = end_x - XW'(1);
        elast  = 1'b1;
        nfirst = efirst;
        ncol   = col_p;
        nopen  = !hits_r;
        done   = 1'b1;
      end
    end
  end

  assign out_free = !out_valid_r || out_tready;
  assign step     = wk_valid_r && (!emit || out_free);
  assign ld_ready = !wk_valid_r || (step && done);
  assign load     = ld_valid && ld_ready;

  always_comb begin
    wk_valid_nxt = wk_valid_r;
    if (load) begin
      wk_valid_nxt = 1'b1;
    end else if (step && done) begin
      wk_valid_nxt = 1'b0;
    end
  end

  // A finished row drops its open run before the next drawn byte
  always_comb begin
    run_open_nxt = step ? nopen : run_open_r;
    if (load && ld_ctl.start_closed) begin
      run_open_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wk_valid_r <= 1'b0;
      run_open_r <= 1'b0;
    end else begin
      wk_valid_r <= wk_valid_nxt;
      run_open_r <= run_open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      run_first_r <= nfirst;
      run_col_r   <= ncol;
    end
    if (load) begin
      pix_r  <= ld_pix;
      base_r <= ld_base;
      row_r  <= ld_row;
      end_r  <= ld_ctl.end_cnt;
      hits_r <= ld_ctl.hits_end;
      pos_r  <= '0;
    end else if (step && !done) begin
      pos_r <= npos;
    end
  end

  // Absolute coordinates
  assign y_val  = {{2{origin_y[CFG_DATA_W-1]}}, origin_y} + {2'b00, row_r};
  assign xf_val = {origin_x[CFG_DATA_W-1], origin_x} + RUN_X_W'(efirst);
  assign xl_val = {origin_x[CFG_DATA_W-1], origin_x} + RUN_X_W'(efinal);

  // Output register decouples the walker from the sink
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_data_r <= {1'b0, COLOR_W'(ecol), xl_val, xf_val, y_val};
      out_last_r <= elast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hdl/planar_to_chunky_run_extractor.sv =====
// Top level: body byte intake, row store access and run output.
//
// Takes the body of an interleaved planar image one byte per transfer and
// returns horizontal color runs with absolute coordinates. Lower-plane bytes
// and bytes that are padded out or clipped never stall. A top-plane byte that
// lands in the drawn area is decoded against the row store (one synchronous
// read). It then holds the run walker until its walk steps have closed every
// run that it ends. The walker closes one run per cycle while the result
// channel accepts, which sets the throughput for busy images. A two-entry
// pipeline (staging register plus walker) lets new bytes flow in while
// earlier runs drain, so the input stalls only when a top-plane byte finds
// both occupied. The row store has no reset and needs no clearing pass; a
// pixel is only decoded after its lower-plane bytes of the same row were
// written. out_tlast marks the final run caused by one byte.
module planar_to_chunky_run_extractor #(
  parameter int MAX_CLIP_WIDTH = 256,
  parameter int PLANE_COUNT    = 3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [p2c_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] body_byte
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [p2c_pkg::OUT_DATA_W-1:0]     out_tdata,  // [17:0] run_y, [34:18] run_x_first,
                                                         // [51:35] run_x_final,
                                                         // [54:52] color_index, [55] zero
  output logic                               out_tlast,  // last_of_burst
  // configuration write port
  input  logic                               cfg_wr_en,
  input  logic [p2c_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [p2c_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import p2c_pkg::*;

  localparam int STORE_ROW = (MAX_CLIP_WIDTH + 7) / 8;
  localparam int ADDR_W    = (STORE_ROW > 1) ? $clog2(STORE_ROW) : 1;
  localparam int LANES     = (PLANE_COUNT > 1) ? PLANE_COUNT - 1 : 1;
  localparam int LSEL_W    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int PLANE_W   = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int XW        = $clog2(MAX_CLIP_WIDTH) + 1;

  // Configuration registers
  logic [CFG_DATA_W-1:0] image_width_r, image_height_r, clip_height_r;
  logic [CLIP_W-1:0]     clip_width_r;
  logic [CFG_DATA_W-1:0] origin_x_r, origin_y_r;

  // Body position
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               pend_r, pend_nxt;
  logic               row_adv;

  // Staging register: drawn top-plane byte, already read from the store, waiting for the walker
  logic             s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [XW-1:0]    s1_base_r;
  logic [ROW_W-1:0] s1_row_r;
  run_ctl_t         s1_ctl_r;
  logic             s1_go;

  // Intake decode
  logic [CFG_DATA_W-1:0]  clip_w16, cw16, w16;
  logic [XW-1:0]          draw_w, base, rem;
  logic [CFG_DATA_W:0]    width_sum;
  logic [ROW_BYTES_W-1:0] pad_len, idx_inc;
  logic                   row_end, active, top_plane, idx_in, drawn, accept, wr_en;
  logic [ADDR_W-1:0]      idx_a;
  run_ctl_t               ctl_in;

  // Store and walker links
  logic [LANES*BYTE_W-1:0]                  rd_data;
  logic [PIX_PER_BYTE-1:0][PLANE_COUNT-1:0] pix;
  logic                                     ld_ready;

  // Configuration decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMAGE_WIDTH_RST;
      image_height_r <= IMAGE_HEIGHT_RST;
      clip_width_r   <= CLIP_WIDTH_RST;
      clip_height_r  <= CLIP_HEIGHT_RST;
      origin_x_r     <= ORIGIN_X_RST;
      origin_y_r     <= ORIGIN_Y_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
        REG_CLIP_WIDTH:   clip_width_r   <= cfg_wdata[CLIP_W-1:0];
        REG_CLIP_HEIGHT:  clip_height_r  <= cfg_wdata;
        REG_ORIGIN_X:     origin_x_r     <= cfg_wdata;
        REG_ORIGIN_Y:     origin_y_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Drawn width and padded plane row length
  assign clip_w16  = CFG_DATA_W'(clip_width_r);
  assign cw16      = (clip_w16 > CFG_DATA_W'(MAX_CLIP_WIDTH)) ? CFG_DATA_W'(MAX_CLIP_WIDTH)
                                                              : clip_w16;
  assign w16       = (image_width_r < cw16) ? image_width_r : cw16;
  assign draw_w    = w16[XW-1:0];
  assign width_sum = {1'b0, image_width_r} + 17'd15;
  assign pad_len   = {width_sum[CFG_DATA_W:4], 1'b0};
  assign idx_inc   = {1'b0, idx_r} + ROW_BYTES_W'(1);
  assign row_end   = idx_inc >= pad_len;

  // Classify the byte at the head of the input from position alone
  assign active    = row_r < image_height_r;
  assign top_plane = plane_r == PLANE_W'(PLANE_COUNT - 1);
  assign idx_in    = idx_r < IDX_W'(STORE_ROW);
  assign idx_a     = idx_r[ADDR_W-1:0];
  assign base      = XW'({idx_a, 3'b000});
  assign rem       = draw_w - base;
  assign drawn     = active && top_plane && (row_r < clip_height_r) && idx_in && (base < draw_w);

  assign ctl_in.start_closed = pend_r;
  assign ctl_in.hits_end     = rem <= XW'(8);
  assign ctl_in.end_cnt      = (rem >= XW'(8)) ? PIX_CNT_W'(8) : rem[PIX_CNT_W-1:0];

  assign s1_go     = s1_valid_r && ld_ready;
  assign in_tready = !drawn || !s1_valid_r || s1_go;
  assign accept    = in_tvalid && in_tready;
  assign wr_en     = accept && active && !top_plane && idx_in;

  // Position counters
  always_comb begin
    idx_nxt   = idx_r;
    plane_nxt = plane_r;
    row_nxt   = row_r;
    row_adv   = 1'b0;
    if (accept && active) begin
      if (row_end) begin
        idx_nxt = '0;
        if (top_plane) begin
          plane_nxt = '0;
          row_nxt   = row_r + ROW_W'(1);
          row_adv   = 1'b1;
        end else begin
          plane_nxt = plane_r + PLANE_W'(1);
        end
      end else begin
        idx_nxt = idx_inc[IDX_W-1:0];
      end
    end
  end

  // Row change pending until the next drawn byte takes it along
  always_comb begin
    pend_nxt = pend_r;
    if (row_adv) begin
      pend_nxt = 1'b1;
    end else if (accept && drawn) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept && drawn) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      plane_r    <= '0;
      row_r      <= '0;
      pend_r     <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      idx_r      <= idx_nxt;
      plane_r    <= plane_nxt;
      row_r      <= row_nxt;
      pend_r     <= pend_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && drawn) begin
      s1_byte_r <= in_tdata;
      s1_base_r <= base;
      s1_row_r  <= row_r;
      s1_ctl_r  <= ctl_in;
    end
  end

  // Lower planes write their lane; a top-plane byte reads the whole entry.
  // Writes and reads come from different transfers, so they never collide.
  p2c_row_store #(
    .DEPTH (STORE_ROW),
    .LANES (LANES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_a),
    .wr_lane (plane_r[LSEL_W-1:0]),
    .wr_byte (in_tdata),
    .rd_en   (accept && drawn),
    .rd_addr (idx_a),
    .rd_data (rd_data)
  );

  // Pixel colors, msb leftmost; plane n gives color bit n
  always_comb begin
    for (int k = 0; k < PIX_PER_BYTE; k++) begin
      pix[k][PLANE_COUNT-1] = s1_byte_r[PIX_PER_BYTE-1-k];
      for (int p = 0; p < PLANE_COUNT - 1; p++) begin
        pix[k][p] = rd_data[p*BYTE_W + PIX_PER_BYTE - 1 - k];
      end
    end
  end

  p2c_run_walker #(
    .PLANE_COUNT (PLANE_COUNT),
    .XW          (XW)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_valid   (s1_valid_r),
    .ld_ready   (ld_ready),
    .ld_pix     (pix),
    .ld_base    (s1_base_r),
    .ld_row     (s1_row_r),
    .ld_ctl     (s1_ctl_r),
    .origin_x   (origin_x_r),
    .origin_y   (origin_y_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hdl/p2c_checker.sv =====
// Port-level checks of the run extractor, bound to the top level.
module p2c_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [p2c_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic                             out_tlast
);
  import p2c_pkg::*;

  logic signed [RUN_X_W-1:0] x_first, x_final;

  assign x_first = out_tdata[RUN_X_FIRST_LSB +: RUN_X_W];
  assign x_final = out_tdata[RUN_X_FINAL_LSB +: RUN_X_W];

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // A run never ends left of where it starts
  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> x_final >= x_first)
    else $error("run final x left of first x");

  // Runs of one byte follow each other without gaps
  a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a burst of runs");

endmodule

bind planar_to_chunky_run_extractor p2c_checker u_p2c_checker (.*);

// ===== verif/p2c_run_checker.sv =====
// Run checker: mirrors the extractor's row state and compares every run transfer.
module p2c_run_checker #(
  parameter int MAX_CLIP_WIDTH = 256,
  parameter int PLANE_COUNT    = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [p2c_pkg::BYTE_W-1:0]      in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [p2c_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            out_tlast,
  input  logic                            cfg_wr_en,
  input  logic [p2c_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [p2c_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              n_pending,
  output int                              n_errors
);
  timeunit 1ns;
  timeprecision 1ps;

  import p2c_pkg::*;

  localparam int STORE_ROW   = (MAX_CLIP_WIDTH + 7) / 8;
  localparam int STORE_DEPTH = PLANE_COUNT * STORE_ROW;

  typedef struct {
    logic [RUN_Y_W-1:0] y;
    logic [RUN_X_W-1:0] x_first;
    logic [RUN_X_W-1:0] x_final;
    logic [COLOR_W-1:0] color;
    logic               last;
  } run_rec_t;

  // shadow registers
  logic [CFG_DATA_W-1:0] img_w, img_h, clip_h, org_x, org_y;
  logic [CLIP_W-1:0]     clip_w;

  // shadow row state
  logic [BYTE_W-1:0] lower_planes [STORE_DEPTH];
  int       byte_pos, plane, row_num, run_x0;
  logic [COLOR_W-1:0] run_col;
  bit       run_open;

  run_rec_t runs_due [$];
  int       errs = 0;

  initial begin
    n_pending = 0;
    n_errors  = 0;
  end

  function automatic void clear_state();
    img_w    = IMAGE_WIDTH_RST;
    img_h    = IMAGE_HEIGHT_RST;
    clip_w   = CLIP_WIDTH_RST;
    clip_h   = CLIP_HEIGHT_RST;
    org_x    = ORIGIN_X_RST;
    org_y    = ORIGIN_Y_RST;
    foreach (lower_planes[i]) lower_planes[i] = '0;
    byte_pos = 0;
    plane    = 0;
    row_num  = 0;
    run_x0   = 0;
    run_col  = '0;
    run_open = 0;
  endfunction

  function automatic void write_register(logic [CFG_INDEX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_IMAGE_WIDTH:  img_w  = v;
      REG_IMAGE_HEIGHT: img_h  = v;
      REG_CLIP_WIDTH:   clip_w = v[CLIP_W-1:0];
      REG_CLIP_HEIGHT:  clip_h = v;
      REG_ORIGIN_X:     org_x  = v;
      REG_ORIGIN_Y:     org_y  = v;
      default: ;
    endcase
  endfunction

  function automatic run_rec_t make_run(int x0, int x1, logic [COLOR_W-1:0] c);
    run_rec_t r;
    int oy;
    int ox;
    oy        = int'($signed(org_y));
    ox        = int'($signed(org_x));
    r.y       = RUN_Y_W'(oy + row_num);
    r.x_first = RUN_X_W'(ox + x0);
    r.x_final = RUN_X_W'(ox + x1);
    r.color   = c;
    r.last    = 1'b0;
    return r;
  endfunction

  // Decode one accepted body byte into the runs it closes
  function automatic void decode_body_byte(logic [BYTE_W-1:0] b);
    int plane_bytes, idx, cw, w, x, sh;
    logic [COLOR_W-1:0] col;
    run_rec_t burst [$];
    plane_bytes = ((int'(img_w) + 15) / 16) * 2;
    idx         = byte_pos;
    // body finished: byte is dropped without touching state
    if (row_num >= int'(img_h)) return;

    if (plane + 1 < PLANE_COUNT) begin
      if (idx < STORE_ROW) lower_planes[plane * STORE_ROW + idx] = b;
    end else if (row_num < int'(clip_h) && idx < STORE_ROW) begin
      cw = (int'(clip_w) > MAX_CLIP_WIDTH) ? MAX_CLIP_WIDTH : int'(clip_w);
      w  = (int'(img_w) < cw) ? int'(img_w) : cw;
      for (x = idx * 8; x < idx * 8 + 8 && x < w; x++) begin
        sh  = 7 - (x & 7);
        col = '0;
        col[PLANE_COUNT-1] = b[sh];
        for (int p = 0; p + 1 < PLANE_COUNT; p++)
          col[p] = lower_planes[p * STORE_ROW + idx][sh];
        if (run_open && col != run_col) begin
          burst.push_back(make_run(run_x0, x - 1, run_col));
          run_open = 0;
        end
        if (!run_open) begin
          run_open = 1;
          run_x0   = x;
          run_col  = col;
        end
        // right edge of the drawn area closes the run
        if (x + 1 == w) begin
          burst.push_back(make_run(run_x0, x, run_col));
          run_open = 0;
        end
      end
    end

    // advance byte / plane / row position; an open run dies at row end
    if (idx + 1 >= plane_bytes) begin
      byte_pos = 0;
      plane++;
      if (plane >= PLANE_COUNT) begin
        plane    = 0;
        run_open = 0;
        row_num++;
      end
    end else begin
      byte_pos = (idx + 1) & 32'h1FFF;
    end

    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) runs_due.push_back(burst[i]);
  endfunction

  task automatic flag_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errs++;
  endtask

  // Compare one run transfer with the oldest expected run
  task automatic check_run();
    run_rec_t want;
    logic [RUN_Y_W-1:0] got_y;
    logic [RUN_X_W-1:0] got_x0, got_x1;
    logic [COLOR_W-1:0] got_c;
    logic               got_pad;
    got_y   = out_tdata[RUN_Y_LSB +: RUN_Y_W];
    got_x0  = out_tdata[RUN_X_FIRST_LSB +: RUN_X_W];
    got_x1  = out_tdata[RUN_X_FINAL_LSB +: RUN_X_W];
    got_c   = out_tdata[COLOR_LSB +: COLOR_W];
    got_pad = |out_tdata[OUT_DATA_W-1:COLOR_LSB+COLOR_W];
    if (runs_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected run y=%0d x=%0d..%0d color=%0d last=%0b",
                              $signed(got_y), $signed(got_x0), $signed(got_x1),
                              got_c, out_tlast));
    end else begin
      want = runs_due.pop_front();
      if (got_y !== want.y || got_x0 !== want.x_first || got_x1 !== want.x_final ||
          got_c !== want.color || out_tlast !== want.last || got_pad !== 1'b0)
        flag_mismatch($sformatf(
          "run got y=%0d x=%0d..%0d c=%0d l=%0b pad=%0b, want y=%0d x=%0d..%0d c=%0d l=%0b",
          $signed(got_y), $signed(got_x0), $signed(got_x1), got_c, out_tlast, got_pad,
          $signed(want.y), $signed(want.x_first), $signed(want.x_final),
          want.color, want.last));
    end
  endtask

  // Sample all channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      runs_due.delete();
    end else begin
      if (cfg_wr_en) write_register(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready) decode_body_byte(in_tdata);
      if (out_tvalid && out_tready) check_run();
    end
    n_pending <= runs_due.size();
    n_errors  <= errs;
  end

endmodule

// ===== verif/tb_planar_to_chunky_run_extractor.sv =====
// Testbench top: clock, reset, body byte and register stimulus, final verdict.
module tb_planar_to_chunky_run_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  import p2c_pkg::*;

  localparam int NPLANES   = 3;
  localparam int ROW_SLOTS = 64;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tlast;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int n_pending, n_errors;

  // stimulus bookkeeping
  bit                steady     = 1'b0;
  int                width_now  = int'(IMAGE_WIDTH_RST);
  int                rows_sent  = 0;
  int                body_count = 0;
  logic [BYTE_W-1:0] row_img [NPLANES][ROW_SLOTS];

  planar_to_chunky_run_extractor uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  p2c_run_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .n_pending  (n_pending),
    .n_errors   (n_errors)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short pauses, a few long ones, none in steady phases
  function automatic int pause_len();
    int r;
    r = $urandom_range(99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // solid bytes give long runs, random bytes give short ones
  function automatic logic [BYTE_W-1:0] body_byte();
    int r;
    r = $urandom_range(99);
    if (r < 20) return 8'h00;
    if (r < 40) return 8'hFF;
    if (r < 50) return $urandom_range(1) ? 8'hF0 : 8'h0F;
    return BYTE_W'($urandom_range(255));
  endfunction

  function automatic int plane_len();
    return (width_now == 0) ? 1 : ((width_now + 15) / 16) * 2;
  endfunction

  function automatic void fill_random_row();
    foreach (row_img[p, j]) row_img[p][j] = body_byte();
  endfunction

  task automatic push_byte(logic [BYTE_W-1:0] b);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    body_count++;
  endtask

  // plane p, bytes j0..j1-1 of the current row
  task automatic send_span(int p, int j0, int j1);
    for (int j = j0; j < j1; j++) begin
      push_byte((j < ROW_SLOTS) ? row_img[p][j] : body_byte());
    end
  endtask

  task automatic send_row();
    for (int p = 0; p < NPLANES; p++) send_span(p, 0, plane_len());
    rows_sent++;
  endtask

  // wait until every expected run is out and the pipeline has emptied
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (r == REG_IMAGE_WIDTH) width_now = int'(v);
  endtask

  // result side: ready stretches with random stalls
  initial begin : drain_side
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      stall = pause_len();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int r, half;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one row at the reset geometry
    fill_random_row();
    send_row();

    // open the body height, all colors in one byte, origin at its extremes
    settle();
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
    write_reg(REG_CLIP_HEIGHT, 16'hFFFF);
    write_reg(REG_IMAGE_WIDTH, 16'd16);
    write_reg(REG_CLIP_WIDTH, 16'd16);
    write_reg(REG_ORIGIN_X, 16'h8000);
    write_reg(REG_ORIGIN_Y, 16'h7FFF);
    fill_random_row();
    row_img[0][0] = 8'h00; row_img[0][1] = 8'hAA;
    row_img[1][0] = 8'h00; row_img[1][1] = 8'hCC;
    row_img[2][0] = 8'h00; row_img[2][1] = 8'hF0;
    send_row();

    // single full-width run at the opposite origin extremes
    settle();
    write_reg(REG_ORIGIN_X, 16'h7FFF);
    write_reg(REG_ORIGIN_Y, 16'h8000);
    foreach (row_img[p, j]) row_img[p][j] = 8'hFF;
    send_row();

    // zero clip width draws nothing
    settle();
    write_reg(REG_CLIP_WIDTH, 16'd0);
    fill_random_row();
    send_row();

    // narrowest image, full clip
    settle();
    write_reg(REG_CLIP_WIDTH, 16'd256);
    write_reg(REG_IMAGE_WIDTH, 16'd8);
    fill_random_row();
    send_row();

    // row beyond the clip height, then the first row drawn again
    settle();
    write_reg(REG_CLIP_HEIGHT, CFG_DATA_W'(rows_sent));
    fill_random_row();
    send_row();
    settle();
    write_reg(REG_CLIP_HEIGHT, CFG_DATA_W'(rows_sent + 1));
    fill_random_row();
    send_row();

    // zero image width: one byte per plane row, nothing drawn
    settle();
    write_reg(REG_CLIP_HEIGHT, 16'hFFFF);
    write_reg(REG_IMAGE_WIDTH, 16'd0);
    fill_random_row();
    send_row();
    send_row();

    // clip shrinks mid-row with a run open; the run is dropped at row end
    settle();
    write_reg(REG_IMAGE_WIDTH, 16'd64);
    write_reg(REG_CLIP_WIDTH, 16'd64);
    write_reg(REG_ORIGIN_X, 16'd0);
    write_reg(REG_ORIGIN_Y, 16'd0);
    foreach (row_img[p, j]) row_img[p][j] = 8'h00;
    half = plane_len() / 2;
    send_span(0, 0, plane_len());
    send_span(1, 0, plane_len());
    send_span(2, 0, half);
    settle();
    write_reg(REG_CLIP_WIDTH, 16'd16);
    send_span(2, half, plane_len());
    rows_sent++;
    settle();
    write_reg(REG_CLIP_WIDTH, 16'd64);
    fill_random_row();
    send_row();

    // random geometry phases until the body byte budget is used
    while (body_count < 180) begin
      settle();
      steady = ($urandom_range(99) < 20);
      r = $urandom_range(99);
      if (r < 60)      write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(1, 64)));
      else if (r < 85) write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(65, 256)));
      else if (r < 95) write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(257, 512)));
      r = $urandom_range(99);
      if (r < 40)      write_reg(REG_CLIP_WIDTH, 16'd256);
      else if (r < 55) write_reg(REG_CLIP_WIDTH, 16'd511);
      else if (r < 65) write_reg(REG_CLIP_WIDTH, 16'd257);
      else if (r < 95) write_reg(REG_CLIP_WIDTH, CFG_DATA_W'($urandom_range(1, 255)));
      else             write_reg(REG_CLIP_WIDTH, 16'd0);
      r = $urandom_range(99);
      if (r < 75)      write_reg(REG_CLIP_HEIGHT, 16'hFFFF);
      else if (r < 88) write_reg(REG_CLIP_HEIGHT, CFG_DATA_W'(rows_sent));
      else             write_reg(REG_CLIP_HEIGHT, CFG_DATA_W'(rows_sent + 1));
      if ($urandom_range(99) < 70)
        write_reg(REG_ORIGIN_X, CFG_DATA_W'($urandom_range(16'hFFFF)));
      if ($urandom_range(99) < 70)
        write_reg(REG_ORIGIN_Y, CFG_DATA_W'($urandom_range(16'hFFFF)));
      repeat ($urandom_range(1, 3)) begin
        fill_random_row();
        send_row();
      end
    end

    // image wider than the store with an oversized clip, sent without pauses
    settle();
    steady = 1'b1;
    write_reg(REG_IMAGE_WIDTH, 16'd300);
    write_reg(REG_CLIP_WIDTH, 16'd511);
    write_reg(REG_CLIP_HEIGHT, 16'hFFFF);
    fill_random_row();
    send_row();

    // body height reached: further bytes are ignored
    settle();
    steady = 1'b0;
    write_reg(REG_IMAGE_WIDTH, 16'd16);
    write_reg(REG_IMAGE_HEIGHT, 16'd1);
    repeat (12) push_byte(body_byte());
    settle();

    if (n_errors == 0 && n_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/p2c_pkg.sv
hdl/p2c_row_store.sv
hdl/p2c_run_walker.sv
hdl/planar_to_chunky_run_extractor.sv
hdl/p2c_checker.sv
verif/p2c_run_checker.sv
verif/tb_planar_to_chunky_run_extractor.sv
